// ===== hdl/abtt_pkg.sv =====
// Package for the array binary tree table: state encoding and field codes.
// No dependencies; used by array_binary_tree_table.
package abtt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LINK_WR,
    ST_NODE_WR,
    ST_LINK_RD,
    ST_KEY_L,
    ST_KEY_R,
    ST_KEY_DONE,
    ST_RESULT
  } state_t;

  localparam logic       OP_INSERT  = 1'b0;
  localparam logic       OP_QUERY   = 1'b1;

  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_ROOT  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

// ===== hdl/abtt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced by array_binary_tree_table.
module abtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/array_binary_tree_table.sv =====
// Array binary tree table top level: node table in three RAMs, linear key search.
// Depends on abtt_pkg and abtt_ram.
//
//   channel | ports                                               | dir
//   --------+-----------------------------------------------------+----
//   request | in_valid in_ready in_op in_node_key in_parent_key   | in
//           | in_side                                             |
//   result  | out_valid out_ready out_status out_slot             | out
//           | out_left_present out_left_key out_right_present     |
//           | out_right_key                                       |
//
// One request at a time. The key search reads one stored key per cycle through
// the key RAM read port, from entry 0 up; a miss reads every stored node, and an
// empty table misses at once. Insert: search, then link write and node write;
// root insert goes straight to node write; full table or unknown side skips to
// result. Query: search, then link read and the left and right key reads.
// Reset clears the node count; RAMs need no clearing. in_ready is low from accept
// until the result is taken; out_ready may stall.
module array_binary_tree_table #(
  parameter int MAX_NODES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_node_key,
  input  logic [7:0] in_parent_key,
  input  logic [1:0] in_side,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [6:0] out_slot,
  output logic       out_left_present,
  output logic [7:0] out_left_key,
  output logic       out_right_present,
  output logic [7:0] out_right_key
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int LNK_W = IDX_W + 1;

  abtt_pkg::state_t state_r, state_nxt;

  logic             op_r;
  logic [1:0]       side_r;
  logic [7:0]       target_r, target_nxt;
  logic [7:0]       node_key_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0] cmp_idx_r;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [LNK_W-1:0] rlink_r, rlink_nxt;
  logic             lp_r, lp_nxt;

  logic [1:0]       status_r, status_nxt;
  logic [6:0]       slot_r, slot_nxt;
  logic             lpo_r, lpo_nxt;
  logic [7:0]       lk_r, lk_nxt;
  logic             rpo_r, rpo_nxt;
  logic [7:0]       rk_r, rk_nxt;

  logic             key_we;
  logic [IDX_W-1:0] key_waddr, key_raddr;
  logic [7:0]       key_rdata;
  logic             left_we, right_we;
  logic [IDX_W-1:0] left_waddr, right_waddr;
  logic [LNK_W-1:0] left_wdata, right_wdata, left_rdata, right_rdata;

  logic             in_acc, out_acc, issue, hit, miss, full;

  assign in_ready  = (state_r == abtt_pkg::ST_IDLE);
  assign out_valid = (state_r == abtt_pkg::ST_RESULT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign issue     = (scan_r < count_r);
  assign hit       = cmp_vld_r && (key_rdata == target_r);
  assign miss      = !cmp_vld_r && !issue;
  assign full      = (count_r >= CNT_W'(MAX_NODES));

  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_left_present  = lpo_r;
  assign out_left_key      = lk_r;
  assign out_right_present = rpo_r;
  assign out_right_key     = rk_r;

  abtt_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(node_key_r),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  abtt_ram #(.WIDTH(LNK_W), .DEPTH(MAX_NODES)) u_left_ram (
    .clk(clk), .we(left_we), .waddr(left_waddr), .wdata(left_wdata),
    .raddr(hit_idx_r), .rdata(left_rdata)
  );

  abtt_ram #(.WIDTH(LNK_W), .DEPTH(MAX_NODES)) u_right_ram (
    .clk(clk), .we(right_we), .waddr(right_waddr), .wdata(right_wdata),
    .raddr(hit_idx_r), .rdata(right_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      abtt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == abtt_pkg::OP_QUERY) begin
            state_nxt = abtt_pkg::ST_SEARCH;
          end else if (!(in_side inside {abtt_pkg::SIDE_LEFT, abtt_pkg::SIDE_RIGHT,
                                         abtt_pkg::SIDE_ROOT}) || full) begin
            state_nxt = abtt_pkg::ST_RESULT;
          end else if (in_side == abtt_pkg::SIDE_ROOT) begin
            state_nxt = abtt_pkg::ST_NODE_WR;
          end else begin
            state_nxt = abtt_pkg::ST_SEARCH;
          end
        end
      end
      abtt_pkg::ST_SEARCH: begin
        if (hit) begin
          state_nxt = (op_r == abtt_pkg::OP_QUERY) ? abtt_pkg::ST_LINK_RD
                                                   : abtt_pkg::ST_LINK_WR;
        end else if (miss) begin
          state_nxt = abtt_pkg::ST_RESULT;
        end
      end
      abtt_pkg::ST_LINK_WR:  state_nxt = abtt_pkg::ST_NODE_WR;
      abtt_pkg::ST_NODE_WR:  state_nxt = abtt_pkg::ST_RESULT;
      abtt_pkg::ST_LINK_RD:  state_nxt = abtt_pkg::ST_KEY_L;
      abtt_pkg::ST_KEY_L:    state_nxt = abtt_pkg::ST_KEY_R;
      abtt_pkg::ST_KEY_R:    state_nxt = abtt_pkg::ST_KEY_DONE;
      abtt_pkg::ST_KEY_DONE: state_nxt = abtt_pkg::ST_RESULT;
      abtt_pkg::ST_RESULT: begin
        if (out_acc) begin
          state_nxt = abtt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abtt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    target_nxt  = target_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = 1'b0;
    hit_idx_nxt = hit_idx_r;
    rlink_nxt   = rlink_r;
    lp_nxt      = lp_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    lpo_nxt     = lpo_r;
    lk_nxt      = lk_r;
    rpo_nxt     = rpo_r;
    rk_nxt      = rk_r;
    key_we      = 1'b0;
    key_waddr   = count_r[IDX_W-1:0];
    key_raddr   = scan_r[IDX_W-1:0];
    left_we     = 1'b0;
    right_we    = 1'b0;
    left_waddr  = count_r[IDX_W-1:0];
    right_waddr = count_r[IDX_W-1:0];
    left_wdata  = '0;
    right_wdata = '0;
    case (state_r)
      abtt_pkg::ST_IDLE: begin
        if (in_acc) begin
          target_nxt = (in_op == abtt_pkg::OP_QUERY) ? in_node_key : in_parent_key;
          scan_nxt   = '0;
          status_nxt = abtt_pkg::STAT_OK;
          slot_nxt   = '0;
          lpo_nxt    = 1'b0;
          lk_nxt     = '0;
          rpo_nxt    = 1'b0;
          rk_nxt     = '0;
          if (in_op == abtt_pkg::OP_INSERT) begin
            if (!(in_side inside {abtt_pkg::SIDE_LEFT, abtt_pkg::SIDE_RIGHT,
                                  abtt_pkg::SIDE_ROOT})) begin
              status_nxt = abtt_pkg::STAT_MISS;
            end else if (full) begin
              status_nxt = abtt_pkg::STAT_FULL;
            end
          end
        end
      end
      abtt_pkg::ST_SEARCH: begin
        cmp_vld_nxt = issue;
        if (issue) begin
          scan_nxt = scan_r + CNT_W'(1);
        end
        if (hit) begin
          hit_idx_nxt = cmp_idx_r[IDX_W-1:0];
        end else if (miss) begin
          status_nxt = abtt_pkg::STAT_MISS;
        end
      end
      abtt_pkg::ST_LINK_WR: begin
        left_waddr  = hit_idx_r;
        right_waddr = hit_idx_r;
        left_wdata  = {1'b1, count_r[IDX_W-1:0]};
        right_wdata = {1'b1, count_r[IDX_W-1:0]};
        left_we     = (side_r == abtt_pkg::SIDE_LEFT);
        right_we    = (side_r == abtt_pkg::SIDE_RIGHT);
      end
      abtt_pkg::ST_NODE_WR: begin
        key_we    = 1'b1;
        left_we   = 1'b1;
        right_we  = 1'b1;
        slot_nxt  = 7'(count_r);
        count_nxt = count_r + CNT_W'(1);
      end
      abtt_pkg::ST_KEY_L: begin
        key_raddr = left_rdata[IDX_W-1:0];
        rlink_nxt = right_rdata;
        lp_nxt    = left_rdata[IDX_W];
        slot_nxt  = 7'(hit_idx_r);
      end
      abtt_pkg::ST_KEY_R: begin
        key_raddr = rlink_r[IDX_W-1:0];
        lpo_nxt   = lp_r;
        lk_nxt    = lp_r ? key_rdata : 8'd0;
      end
      abtt_pkg::ST_KEY_DONE: begin
        rpo_nxt = rlink_r[IDX_W];
        rk_nxt  = rlink_r[IDX_W] ? key_rdata : 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= abtt_pkg::ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_op;
      side_r     <= in_side;
      node_key_r <= in_node_key;
    end
    target_r  <= target_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= scan_r;
    hit_idx_r <= hit_idx_nxt;
    rlink_r   <= rlink_nxt;
    lp_r      <= lp_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    lpo_r     <= lpo_nxt;
    lk_r      <= lk_nxt;
    rpo_r     <= rpo_nxt;
    rk_r      <= rk_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES))
    else $error("node count above table size");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == abtt_pkg::STAT_FULL) |-> full)
    else $error("full status with free slots");

  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abtt_pkg::ST_NODE_WR) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance node count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abtt_pkg::ST_SEARCH && cmp_vld_r) |-> (cmp_idx_r < count_r))
    else $error("search compared an entry beyond node count");

endmodule
